### rtl/tps_pkg.sv
`timescale 1ns / 1ps

package tps_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_TICK   = 2'd2,
        OP_SAMPLE = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_SAMPLE_RATE = 1'b0,
        REG_TONE_AMP    = 1'b1
    } cfg_reg_t;

    localparam logic [15:0] SAMPLE_RATE_RESET = 16'd16000;
    localparam logic [14:0] TONE_AMP_RESET    = 15'd9000;

    // Input tdata layout, lowest bit first
    localparam int IN_DATA_W    = 48;
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_TONE_BIT  = 4;
    localparam int IN_FREQ_LSB  = 5;
    localparam int IN_DUR_LSB   = 21;
    localparam int IN_COUNT_LSB = 37;

    // Output tdata layout
    localparam int OUT_DATA_W     = 24;
    localparam int OUT_TONE_BIT   = 16;
    localparam int OUT_RUNNING_BIT = 17;

    // Divider step counts
    localparam logic [5:0] DIV_SHORT_STEPS = 6'd16;
    localparam logic [5:0] DIV_LONG_STEPS  = 6'd32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_TICK,
        ST_TICK_EVAL,
        ST_RD_STEP,
        ST_APPLY,
        ST_DIV_PER,
        ST_PER_RUN,
        ST_DIV_MOD,
        ST_MOD_RUN,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic ready;
        logic decode;
        logic tick_eval;
        logic enter;
        logic div_start;
        logic div_long;
        logic sample_set;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic count_nz;
        logic tone_active;
        logic tick_enter;
        logic div_busy;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/tone_pattern_sequencer.sv
`timescale 1ns / 1ps

// Tone pattern sequencer: load transactions fill a step table (tone flag,
// frequency, duration), a start transaction begins playback, millisecond
// tick transactions step through the pattern, and sample transactions
// return a +/- amplitude square wave (0 while silent). Every input
// transaction yields exactly one output transaction, and items are handled
// one at a time. A sounding sample uses the shared bit-serial divider,
// which runs 16 steps for rate/frequency and then 32 steps for cursor mod
// period. The next input is taken while a finished result waits on the
// output register. Table slots read before they were loaded return
// unspecified data.
module tone_pattern_sequencer #(
    parameter int MAX_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] step_index, [4] step_tone_on, [20:5] step_frequency_hz,
    // [36:21] step_duration_ms, [41:37] step_count, [47:42] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] sample_value, [16] tone_sounding, [17] pattern_running,
    // [23:18] zero
    output logic [23:0] m_axis_tdata
);
    import tps_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t st;

    tps_controller u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .st       (st),
        .cmd      (cmd)
    );

    tps_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_reg_t'(cfg_addr)),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_op     (op_t'(s_axis_tuser)),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .st        (st),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.ready;

endmodule

### rtl/tps_ram.sv
`timescale 1ns / 1ps

module tps_ram #(
    parameter int WIDTH  = 33,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/tps_divider.sv
`timescale 1ns / 1ps

module tps_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        long_op,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [15:0] quotient,
    output logic [15:0] remainder
);
    import tps_pkg::*;

    logic [31:0] q_reg;
    logic [15:0] rem_reg;
    logic [15:0] dsr_reg;
    logic [5:0]  cnt_reg;

    logic [16:0] shifted;
    logic        ge;
    logic [15:0] rem_next;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, q_reg[31]};
        ge       = shifted >= {1'b0, dsr_reg};
        rem_next = ge ? 16'(shifted - {1'b0, dsr_reg}) : shifted[15:0];
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= long_op ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // Quotient and remainder shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy)
        begin
            q_reg   <= {q_reg[30:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign busy      = cnt_reg != 6'd0;
    assign quotient  = q_reg[15:0];
    assign remainder = rem_reg;

endmodule

### rtl/tps_datapath.sv
`timescale 1ns / 1ps

module tps_datapath #(
    parameter int MAX_STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  tps_pkg::cfg_reg_t               cfg_addr,
    input  logic [15:0]                     cfg_wdata,
    input  logic                            in_valid,
    input  tps_pkg::op_t                    in_op,
    input  logic [tps_pkg::IN_DATA_W-1:0]   in_data,
    input  tps_pkg::ctl_cmd_t               cmd,
    output tps_pkg::dp_status_t             st,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [tps_pkg::OUT_DATA_W-1:0]  out_data
);
    import tps_pkg::*;

    localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // Latched input item
    op_t         op_reg;
    logic [3:0]  idx_reg;
    logic        tone_in_reg;
    logic [15:0] freq_in_reg;
    logic [15:0] dur_in_reg;
    logic [4:0]  count_reg;

    // Sequencer state
    logic [4:0]  total_reg;
    logic [4:0]  ptr_reg;
    logic [15:0] elapsed_reg;
    logic        running_reg;
    logic        on_reg;
    logic [15:0] freq_reg;
    logic [31:0] cursor_reg;
    logic [15:0] rate_reg;
    logic [14:0] amp_reg;
    logic [15:0] period_reg;
    logic [15:0] sample_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic        accept;
    logic        ram_we;
    logic [32:0] ram_rdata;
    logic        rd_tone;
    logic [15:0] rd_freq;
    logic [15:0] rd_dur;
    logic [4:0]  count_sat;
    logic [15:0] elapsed_inc;
    logic        tick_live;
    logic        tick_adv;
    logic [5:0]  ptr_inc;
    logic        div_busy;
    logic [15:0] div_quo;
    logic [15:0] div_rem;
    logic [15:0] period_new;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic [15:0] sample_pos;
    logic [15:0] sample_neg;

    assign accept = in_valid && cmd.ready;

    // Step table
    assign ram_we = cmd.decode && (op_reg == OP_LOAD) && (int'(idx_reg) < MAX_STEPS);

    tps_ram #(
        .WIDTH (33),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(idx_reg)),
        .wdata ({tone_in_reg, freq_in_reg, dur_in_reg}),
        .raddr (AW'(ptr_reg)),
        .rdata (ram_rdata)
    );

    assign rd_tone = ram_rdata[32];
    assign rd_freq = ram_rdata[31:16];
    assign rd_dur  = ram_rdata[15:0];

    // Step count clamps to the table depth
    assign count_sat = (int'(count_reg) > MAX_STEPS) ? 5'(MAX_STEPS) : count_reg;

    // Tick evaluation
    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign ptr_inc     = {1'b0, ptr_reg} + 6'd1;
    assign tick_live   = running_reg && (ptr_reg < total_reg);
    assign tick_adv    = elapsed_inc >= rd_dur;

    // Shared divider: rate / frequency, then cursor mod period
    assign period_new   = (div_quo <= 16'd1) ? 16'd2 : div_quo;
    assign div_dividend = cmd.div_long ? cursor_reg : {rate_reg, 16'd0};
    assign div_divisor  = cmd.div_long ? period_new : freq_reg;

    tps_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .long_op   (cmd.div_long),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign sample_pos = {1'b0, amp_reg};
    assign sample_neg = 16'd0 - {1'b0, amp_reg};

    // Latch the item on each input transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= in_op;
            idx_reg     <= in_data[IN_IDX_LSB +: 4];
            tone_in_reg <= in_data[IN_TONE_BIT];
            freq_in_reg <= in_data[IN_FREQ_LSB +: 16];
            dur_in_reg  <= in_data[IN_DUR_LSB +: 16];
            count_reg   <= in_data[IN_COUNT_LSB +: 5];
        end
        if (cmd.div_start && cmd.div_long)
        begin
            period_reg <= period_new;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= SAMPLE_RATE_RESET;
            amp_reg  <= TONE_AMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SAMPLE_RATE: rate_reg <= cfg_wdata;
                REG_TONE_AMP:    amp_reg  <= cfg_wdata[14:0];
                default:         rate_reg <= rate_reg;
            endcase
        end
    end

    // Pattern state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            ptr_reg     <= '0;
            elapsed_reg <= '0;
            running_reg <= 1'b0;
            on_reg      <= 1'b0;
            freq_reg    <= '0;
            cursor_reg  <= '0;
            sample_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                sample_reg <= '0;
            end

            // Start pattern
            if (cmd.decode && (op_reg == OP_START))
            begin
                total_reg   <= count_sat;
                ptr_reg     <= '0;
                running_reg <= count_reg != 5'd0;
                if (count_reg == 5'd0)
                begin
                    on_reg   <= 1'b0;
                    freq_reg <= '0;
                end
            end

            // Millisecond tick
            if (cmd.tick_eval && running_reg)
            begin
                if (!tick_live)
                begin
                    on_reg      <= 1'b0;
                    freq_reg    <= '0;
                    running_reg <= 1'b0;
                end
                else
                begin
                    elapsed_reg <= elapsed_inc;
                    if (tick_adv)
                    begin
                        ptr_reg <= ptr_inc[4:0];
                        if (ptr_inc >= {1'b0, total_reg})
                        begin
                            on_reg      <= 1'b0;
                            freq_reg    <= '0;
                            running_reg <= 1'b0;
                        end
                    end
                end
            end

            // Apply the step at the pointer
            if (cmd.enter)
            begin
                elapsed_reg <= '0;
                if (rd_tone && (rd_dur != 16'd0))
                begin
                    on_reg   <= 1'b1;
                    freq_reg <= rd_freq;
                end
                else
                begin
                    on_reg   <= 1'b0;
                    freq_reg <= '0;
                end
                if (rd_dur == 16'd0)
                begin
                    running_reg <= 1'b0;
                end
            end

            // Square wave sample from cursor mod period
            if (cmd.sample_set)
            begin
                sample_reg <= (div_rem < (period_reg >> 1)) ? sample_pos : sample_neg;
                cursor_reg <= cursor_reg + 32'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= {6'd0, running_reg, on_reg, sample_reg};
        end
    end

    // Status to the controller
    always_comb
    begin
        st.op          = op_reg;
        st.count_nz    = count_reg != 5'd0;
        st.tone_active = on_reg && (freq_reg != 16'd0);
        st.tick_enter  = running_reg && tick_live && tick_adv
                         && (ptr_inc < {1'b0, total_reg});
        st.div_busy    = div_busy;
        st.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/tps_controller.sv
`timescale 1ns / 1ps

module tps_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tps_pkg::dp_status_t st,
    output tps_pkg::ctl_cmd_t   cmd
);
    import tps_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                case (st.op)
                    OP_LOAD:   state_next = ST_FINISH;
                    OP_START:  state_next = st.count_nz ? ST_RD_STEP : ST_FINISH;
                    OP_TICK:   state_next = ST_RD_TICK;
                    OP_SAMPLE: state_next = st.tone_active ? ST_DIV_PER : ST_FINISH;
                    default:   state_next = ST_FINISH;
                endcase
            end
            ST_RD_TICK:
            begin
                state_next = ST_TICK_EVAL;
            end
            ST_TICK_EVAL:
            begin
                cmd.tick_eval = 1'b1;
                state_next    = st.tick_enter ? ST_RD_STEP : ST_FINISH;
            end
            ST_RD_STEP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.enter  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_DIV_PER:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_PER_RUN;
            end
            ST_PER_RUN:
            begin
                if (!st.div_busy)
                begin
                    state_next = ST_DIV_MOD;
                end
            end
            ST_DIV_MOD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_long  = 1'b1;
                state_next    = ST_MOD_RUN;
            end
            ST_MOD_RUN:
            begin
                cmd.div_long = 1'b1;
                if (!st.div_busy)
                begin
                    cmd.sample_set = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/tps_checker.sv
`timescale 1ns / 1ps

module tps_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Held result stays put until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // One item in flight: ready drops after each input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    // A sounding tone only exists inside a running pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[17])
        else $error("tone sounding without a running pattern");

    // Nonzero samples only while a tone sounds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[15:0] != 16'd0) |-> m_axis_tdata[16])
        else $error("nonzero sample while silent");

endmodule

bind tone_pattern_sequencer tps_checker u_tps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### bench/tb_tone_pattern_sequencer.sv
`timescale 1ns / 1ps

module tb_tone_pattern_sequencer;
    import tps_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TABLE_SLOTS  = 16;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_MAX   = 10;

    // Expected fields of one output transaction
    typedef struct packed {
        logic [15:0] sample;
        logic        tone;
        logic        running;
    } tone_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = REG_SAMPLE_RATE;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = 48'd0;
    logic [1:0]  s_axis_tuser = OP_LOAD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    // Predictor state: step table, playback position, tone and registers
    logic        tbl_tone [TABLE_SLOTS] = '{default: 1'b0};
    logic [15:0] tbl_freq [TABLE_SLOTS] = '{default: 16'd0};
    logic [15:0] tbl_dur  [TABLE_SLOTS] = '{default: 16'd0};
    logic [4:0]  pat_len = 5'd0;
    logic [4:0]  pat_pos = 5'd0;
    logic [15:0] ms_in_step = 16'd0;
    logic        playing = 1'b0;
    logic        sounding = 1'b0;
    logic [15:0] tone_freq = 16'd0;
    logic [31:0] wave_cursor = 32'd0;
    logic [15:0] rate_cfg = SAMPLE_RATE_RESET;
    logic [14:0] amp_cfg = TONE_AMP_RESET;

    tone_result_t pending_results [$];
    int items_sent = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_request = 0;
    int stall_left = 0;

    tone_pattern_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic void go_quiet();
        sounding = 1'b0;
        tone_freq = 16'd0;
    endfunction

    function automatic void stop_playback();
        go_quiet();
        playing = 1'b0;
    endfunction

    // Apply the step under pat_pos; a zero duration ends the pattern
    function automatic void load_current_step();
        logic [15:0] dur;
        dur = 16'd0;
        if (pat_pos < TABLE_SLOTS)
        begin
            if (tbl_tone[pat_pos[3:0]])
            begin
                sounding = 1'b1;
                tone_freq = tbl_freq[pat_pos[3:0]];
            end
            else
                go_quiet();
            dur = tbl_dur[pat_pos[3:0]];
        end
        else
            go_quiet();
        ms_in_step = 16'd0;
        if (dur == 16'd0)
            stop_playback();
    endfunction

    function automatic tone_result_t predict_tone_result(input op_t op, input logic [47:0] d);
        tone_result_t r;
        logic [3:0]   idx;
        logic [4:0]   cnt;
        logic [31:0]  period;
        r.sample = 16'd0;
        case (op)
            OP_LOAD:
            begin
                idx = d[3:0];
                tbl_tone[idx] = d[4];
                tbl_freq[idx] = d[20:5];
                tbl_dur[idx]  = d[36:21];
            end
            OP_START:
            begin
                cnt = d[41:37];
                pat_len = (cnt > TABLE_SLOTS) ? 5'(TABLE_SLOTS) : cnt;
                pat_pos = 5'd0;
                playing = (pat_len != 5'd0);
                if (!playing)
                    go_quiet();
                else
                    load_current_step();
            end
            OP_TICK:
            begin
                if (playing)
                begin
                    if (pat_pos >= pat_len || pat_pos >= TABLE_SLOTS)
                        stop_playback();
                    else
                    begin
                        if (ms_in_step != 16'hFFFF)
                            ms_in_step++;
                        if (ms_in_step >= tbl_dur[pat_pos[3:0]])
                        begin
                            pat_pos++;
                            if (pat_pos >= pat_len)
                                stop_playback();
                            else
                                load_current_step();
                        end
                    end
                end
            end
            default:
            begin
                // square wave: high for the first half of each period
                if (sounding && tone_freq != 16'd0)
                begin
                    period = 32'(rate_cfg) / 32'(tone_freq);
                    if (period <= 32'd1)
                        period = 32'd2;
                    if ((wave_cursor % period) < (period / 2))
                        r.sample = 16'({1'b0, amp_cfg});
                    else
                        r.sample = 16'd0 - 16'({1'b0, amp_cfg});
                    wave_cursor++;
                end
            end
        endcase
        r.tone = sounding;
        r.running = playing;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Output side: ready pattern with optional long hold-off
    // ---------------------------------------------------------------

    always @(negedge clk)
    begin
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic flag_mismatch(input string field, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("mismatch on %s, result %0d: expected %h, got %h",
                     field, results_seen, exp_v, got_v);
    endtask

    // Compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin
        tone_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result", 16'd0, m_axis_tdata[15:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[15:0] !== want.sample)
                    flag_mismatch("sample_value", want.sample, m_axis_tdata[15:0]);
                if (m_axis_tdata[OUT_TONE_BIT] !== want.tone)
                    flag_mismatch("tone_sounding", 16'(want.tone),
                                  16'(m_axis_tdata[OUT_TONE_BIT]));
                if (m_axis_tdata[OUT_RUNNING_BIT] !== want.running)
                    flag_mismatch("pattern_running", 16'(want.running),
                                  16'(m_axis_tdata[OUT_RUNNING_BIT]));
            end
            results_seen++;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // tdata: idx, tone, freq, dur, count from bit 0 up
    function automatic logic [47:0] pack_item(input logic [3:0] idx, input logic tone,
                                              input logic [15:0] freq, input logic [15:0] dur,
                                              input logic [4:0] cnt);
        return {6'd0, cnt, dur, freq, tone, idx};
    endfunction

    function automatic logic [47:0] random_payload();
        return {6'd0, 10'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [15:0] rand_frequency();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 16'd0;
        else if (pick < 60)
            return 16'($urandom_range(100, 4000));
        else
            return 16'($urandom);
    endfunction

    // Mostly short steps so patterns actually advance
    function automatic logic [15:0] rand_duration();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return 16'd0;
        else if (pick < 75)
            return 16'($urandom_range(1, 4));
        else if (pick < 90)
            return 16'($urandom_range(5, 40));
        else
            return 16'($urandom);
    endfunction

    // Offer one transaction; valid stays high if the caller sends again
    task automatic send_item(input op_t op, input logic [47:0] data);
        tone_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = predict_tone_result(op, data);
        pending_results.push_back(r);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_load(input logic [3:0] idx, input logic tone,
                             input logic [15:0] freq, input logic [15:0] dur);
        send_item(OP_LOAD, pack_item(idx, tone, freq, dur, 5'($urandom)));
    endtask

    task automatic send_start(input logic [4:0] cnt);
        send_item(OP_START, pack_item(4'($urandom), 1'($urandom), 16'($urandom),
                                      16'($urandom), cnt));
    endtask

    task automatic send_tick();
        send_item(OP_TICK, random_payload());
    endtask

    task automatic send_sample();
        send_item(OP_SAMPLE, random_payload());
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register write; only called with nothing in flight
    task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (r == REG_SAMPLE_RATE)
            rate_cfg = v;
        else
            amp_cfg = v[14:0];
        @(negedge clk);
    endtask

    // One item of a playing pattern: mostly ticks and samples
    task automatic send_pattern_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)
            send_tick();
        else if (pick < 95)
            send_sample();
        else
            send_load(4'($urandom), ($urandom_range(3) != 0), rand_frequency(),
                      rand_duration());
    endtask

    task automatic play_random_pattern();
        int loads;
        int body;
        loads = $urandom_range(1, 6);
        body = $urandom_range(8, 30);
        repeat (loads)
            send_load(4'($urandom), ($urandom_range(3) != 0), rand_frequency(),
                      rand_duration());
        if ($urandom_range(9) == 0)
            send_start(5'($urandom));
        else
            send_start(5'($urandom_range(1, TABLE_SLOTS)));
        repeat (body)
            send_pattern_item();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Empty start, tick with nothing playing, sample while silent
    task automatic test_idle_items();
        send_start(5'd0);
        send_tick();
        send_sample();
    endtask

    // Zero-duration first step, count above table size
    task automatic test_terminal_step();
        send_load(4'd0, 1'b1, 16'hFFFF, 16'd0);
        send_start(5'd31);
    endtask

    // Tone, silent step, then a tone at zero frequency
    task automatic test_step_walk();
        send_load(4'd0, 1'b1, 16'd1000, 16'd2);
        send_load(4'd1, 1'b0, 16'd0, 16'd1);
        send_load(4'd2, 1'b1, 16'd0, 16'hFFFF);
        send_start(5'd3);
        send_sample();
        send_sample();
        send_tick();
        send_tick();
        send_sample();
        send_tick();
        send_sample();
    endtask

    // Period clamped to 2, both from a high tone and from a zero rate
    task automatic test_short_period();
        send_load(4'd0, 1'b1, 16'd16000, 16'd1);
        send_load(4'd1, 1'b1, 16'd440, 16'd0);
        send_start(5'd2);
        send_sample();
        send_sample();
        send_tick();
        wait_results_drained();
        write_reg(REG_SAMPLE_RATE, 16'd0);
        send_start(5'd2);
        send_sample();
        send_sample();
        wait_results_drained();
        write_reg(REG_SAMPLE_RATE, SAMPLE_RATE_RESET);
    endtask

    // Every slot loaded so no later pattern reads an empty one
    task automatic test_fill_table();
        for (int i = 0; i < TABLE_SLOTS; i++)
            send_load(4'(i), ($urandom_range(3) != 0), rand_frequency(), rand_duration());
    endtask

    task automatic test_random_phase(input int tx_idle, input int rx_idle,
                                     input logic [15:0] rate, input logic [15:0] amp,
                                     input int n_items);
        int target;
        wait_results_drained();
        write_reg(REG_SAMPLE_RATE, rate);
        write_reg(REG_TONE_AMP, amp);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(99) < 15)
                send_item(op_t'($urandom_range(3)), random_payload());
            else
                play_random_pattern();
        end
    endtask

    // Output held off long enough that the input side backs up
    task automatic test_output_stall();
        wait_results_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_start(5'($urandom_range(1, TABLE_SLOTS)));
        stall_request = 400;
        repeat (12)
            send_pattern_item();
        wait_results_drained();
    endtask

    // Sender waits for every result before going on
    task automatic test_sender_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4)
        begin
            play_random_pattern();
            wait_results_drained();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 57;
        test_idle_items();
        test_terminal_step();
        test_step_walk();
        test_short_period();
        test_fill_table();

        test_random_phase(23, 57, SAMPLE_RATE_RESET, 16'(TONE_AMP_RESET), 180);
        test_random_phase(57, 23, 16'hFFFF, 16'hFFFF, 180);
        test_random_phase(0, 0, 16'd1, 16'd0, 90);
        test_random_phase(0, 0, 16'($urandom_range(8000, 48000)), 16'($urandom), 90);
        test_output_stall();
        test_sender_pause();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/tps_pkg.sv
rtl/tps_ram.sv
rtl/tps_divider.sv
rtl/tps_datapath.sv
rtl/tps_controller.sv
rtl/tone_pattern_sequencer.sv
rtl/tps_checker.sv
bench/tb_tone_pattern_sequencer.sv
